// File: rtl/core/cpr_pkg.sv
// Shared constants, types and cell control codes for the clock page replacement block.
// No dependencies. Every other file refers to this package by scoped names.
package cpr_pkg;

  localparam int FRAMES  = 4;
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int PAGE_W  = 20;
  localparam int CNT_W   = 32;

  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_HIT,
    CELL_SWEEP
  } cell_op_t;

  typedef struct packed {
    logic token;
    logic match;
    logic ref_bit;
    logic valid;
  } cell_stat_t;

  typedef struct packed {
    logic [FRAMES-1:0]  tok;
    logic [FRAMES-1:0]  match;
    logic               hit;
    logic [FRAME_W-1:0] hit_idx;
    logic [FRAME_W-1:0] hand_idx;
    logic               hand_ref;
    logic               hand_valid;
    logic [PAGE_W-1:0]  hand_page;
  } ring_stat_t;

endpackage

// File: rtl/core/cpr_if.sv
// Valid/ready channel interfaces for page references and replacement results.
// Depends on cpr_pkg for field widths.
interface cpr_in_if;
  logic                      valid;
  logic                      ready;
  logic [cpr_pkg::PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

interface cpr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [cpr_pkg::FRAME_W-1:0] frame_index;
  logic                        evicted;
  logic [cpr_pkg::PAGE_W-1:0]  evicted_page;
  logic [cpr_pkg::CNT_W-1:0]   replacement_count;

  modport source (output valid, output hit, output frame_index, output evicted,
                  output evicted_page, output replacement_count, input ready);
  modport sink (input valid, input hit, input frame_index, input evicted,
                input evicted_page, input replacement_count, output ready);
endinterface

// File: rtl/core/cpr_cell.sv
// One page frame: page, valid bit, reference bit and its share of the clock hand token.
// Depends on cpr_pkg for widths, cell op codes and the status struct.
module cpr_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       home,
  input  cpr_pkg::cell_op_t          op,
  input  logic [cpr_pkg::PAGE_W-1:0] page_in,
  input  logic                       prev_token,
  input  logic                       prev_match,
  output cpr_pkg::cell_stat_t        stat,
  output logic [cpr_pkg::PAGE_W-1:0] page_out
);

  logic [cpr_pkg::PAGE_W-1:0] page_r, page_nxt;
  logic                       valid_r, valid_nxt;
  logic                       ref_r, ref_nxt;
  logic                       token_r, token_nxt;
  logic                       match;

  assign match = valid_r && (page_r == page_in);

  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    ref_nxt   = ref_r;
    token_nxt = token_r;
    unique case (op)
      cpr_pkg::CELL_HIT: begin
        // The hand lands on the frame after the matching one.
        ref_nxt   = ref_r | match;
        token_nxt = prev_match;
      end
      cpr_pkg::CELL_SWEEP: begin
        // The hand moves one frame on every sweep step, including the claiming one.
        token_nxt = prev_token;
        if (token_r) begin
          if (ref_r) begin
            ref_nxt = 1'b0;
          end else begin
            page_nxt  = page_in;
            valid_nxt = 1'b1;
            ref_nxt   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r  <= '0;
      valid_r <= 1'b0;
      ref_r   <= 1'b0;
      token_r <= home;
    end else begin
      page_r  <= page_nxt;
      valid_r <= valid_nxt;
      ref_r   <= ref_nxt;
      token_r <= token_nxt;
    end
  end

  assign stat.token   = token_r;
  assign stat.match   = match;
  assign stat.ref_bit = ref_r;
  assign stat.valid   = valid_r;
  assign page_out     = page_r;

endmodule

// File: rtl/core/cpr_ring.sv
// Ring of frame cells with the token passed cell to cell, plus the status encoders.
// Depends on cpr_pkg and cpr_cell.
module cpr_ring (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cpr_pkg::cell_op_t          op,
  input  logic [cpr_pkg::PAGE_W-1:0] page_in,
  output cpr_pkg::ring_stat_t        rstat
);

  cpr_pkg::cell_stat_t        cstat [cpr_pkg::FRAMES];
  logic [cpr_pkg::PAGE_W-1:0] cpage [cpr_pkg::FRAMES];

  for (genvar i = 0; i < cpr_pkg::FRAMES; i++) begin : g_cell
    localparam int Prev = (i + cpr_pkg::FRAMES - 1) % cpr_pkg::FRAMES;
    cpr_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .home       ((i == 0) ? 1'b1 : 1'b0),
      .op         (op),
      .page_in    (page_in),
      .prev_token (cstat[Prev].token),
      .prev_match (cstat[Prev].match),
      .stat       (cstat[i]),
      .page_out   (cpage[i])
    );
  end

  // Exactly one cell holds the token and at most one valid frame matches.
  always_comb begin
    rstat = '0;
    for (int i = 0; i < cpr_pkg::FRAMES; i++) begin
      rstat.tok[i]   = cstat[i].token;
      rstat.match[i] = cstat[i].match;
      if (cstat[i].match) begin
        rstat.hit     = 1'b1;
        rstat.hit_idx = cpr_pkg::FRAME_W'(i);
      end
      if (cstat[i].token) begin
        rstat.hand_idx   = cpr_pkg::FRAME_W'(i);
        rstat.hand_ref   = cstat[i].ref_bit;
        rstat.hand_valid = cstat[i].valid;
        rstat.hand_page  = cpage[i];
      end
    end
  end

endmodule

// File: rtl/core/clock_page_replacement.sv
// Top level of the clock (second-chance) page replacement block: control FSM and result register.
// Depends on cpr_pkg, cpr_if (cpr_in_if, cpr_out_if) and cpr_ring.

// One page reference is handled at a time. After a transfer on the input, the check state
// compares the page against all frames in parallel; a hit completes there. A miss then sweeps
// the clock hand one frame per cycle through the ring of frame cells, clearing reference bits,
// until a frame with a clear bit takes the page; that is 1 to FRAMES+1 steps, and the claiming
// step waits for room in the output register. Empty frames never match and are taken as soon
// as the hand reaches them. The result sits in an output register, so a new reference is taken
// while the previous result still waits; the core stalls only when a result is ready and that
// register is still full. The replacement count saturates.
module clock_page_replacement (
  input logic             clk,
  input logic             rst_n,
  cpr_in_if.sink          in_if,
  cpr_out_if.source       out_if
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SWEEP
  } state_t;

  state_t                      state_r;
  logic [cpr_pkg::PAGE_W-1:0]  page_r;
  logic [cpr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [cpr_pkg::FRAME_W-1:0] out_idx_r;
  logic                        out_evicted_r;
  logic [cpr_pkg::PAGE_W-1:0]  out_page_r;
  logic [cpr_pkg::CNT_W-1:0]   out_cnt_r;

  cpr_pkg::cell_op_t   cell_op;
  cpr_pkg::ring_stat_t rstat;
  logic                out_free;
  logic                claim;
  logic                evict;
  logic                out_load;

  cpr_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (cell_op),
    .page_in (page_r),
    .rstat   (rstat)
  );

  assign out_free = !out_valid_r || out_if.ready;
  assign claim    = (state_r == S_SWEEP) && !rstat.hand_ref && out_free;
  assign evict    = claim && rstat.hand_valid;
  assign cnt_nxt  = (evict && (cnt_r != '1)) ? cnt_r + 1'b1 : cnt_r;
  assign out_load = ((state_r == S_CHECK) && rstat.hit && out_free) || claim;

  always_comb begin
    cell_op = cpr_pkg::CELL_IDLE;
    unique case (state_r)
      S_CHECK: begin
        if (rstat.hit && out_free) cell_op = cpr_pkg::CELL_HIT;
      end
      S_SWEEP: begin
        // Clearing steps never wait; the claiming step waits for room in the output.
        if (rstat.hand_ref || out_free) cell_op = cpr_pkg::CELL_SWEEP;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            page_r  <= in_if.page_number;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!rstat.hit) begin
            state_r <= S_SWEEP;
          end else if (out_free) begin
            out_hit_r     <= 1'b1;
            out_idx_r     <= rstat.hit_idx;
            out_evicted_r <= 1'b0;
            out_page_r    <= '0;
            out_cnt_r     <= cnt_r;
            state_r       <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (claim) begin
            out_hit_r     <= 1'b0;
            out_idx_r     <= rstat.hand_idx;
            out_evicted_r <= rstat.hand_valid;
            out_page_r    <= rstat.hand_valid ? rstat.hand_page : '0;
            out_cnt_r     <= cnt_nxt;
            cnt_r         <= cnt_nxt;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready              = (state_r == S_IDLE);
  assign out_if.valid             = out_valid_r;
  assign out_if.hit               = out_hit_r;
  assign out_if.frame_index       = out_idx_r;
  assign out_if.evicted           = out_evicted_r;
  assign out_if.evicted_page      = out_page_r;
  assign out_if.replacement_count = out_cnt_r;

`ifndef SYNTHESIS
  a_one_hand: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(rstat.tok))
    else $error("clock hand token is not held by exactly one frame");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(rstat.match))
    else $error("page is resident in more than one frame");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !(out_if.hit && out_if.evicted))
    else $error("result reports both a hit and an eviction");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) && !claim |=> $stable(cnt_r))
    else $error("replacement count changed without a claim");
`endif

endmodule
